>>> design/joystick_rate_demand_shaper_core_macros.svh
// assertion macros shared by the joystick rate demand shaper checkers
`ifndef JOYSTICK_RATE_DEMAND_SHAPER_CORE_MACROS_SVH
`define JOYSTICK_RATE_DEMAND_SHAPER_CORE_MACROS_SVH

// implication into the next cycle, off while reset is asserted
`define JRDS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("jrds check failed");

// implication in the same cycle, off while reset is asserted
`define JRDS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("jrds check failed");

// implication into the next cycle, also checked during reset
`define JRDS_ASSERT_NEXT_ANY(label, ante, cons) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("jrds check failed");

`endif

>>> design/jrds_pkg.sv
// shared types and constants for the joystick rate demand shaper
package jrds_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int DEMAND_W   = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int DBAND_W    = 15;
    localparam int ODBAND_W   = 31;
    localparam int GAIN_W     = 32;
    localparam int PROD_W     = 49;
    localparam int FRAC_SHIFT = 15;
    localparam int MAG_W      = PROD_W - FRAC_SHIFT;

    localparam int DRIFT_DEFAULT = 0;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [DEMAND_W-1:0] t_demand;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INPUT_OFFSET    = 3'd0,
        CFG_INPUT_DEADBAND  = 3'd1,
        CFG_CUTPOINT        = 3'd2,
        CFG_LOW_GAIN        = 3'd3,
        CFG_HIGH_GAIN       = 3'd4,
        CFG_DEMAND_MAX      = 3'd5,
        CFG_DEMAND_MIN      = 3'd6,
        CFG_OUTPUT_DEADBAND = 3'd7
    } t_cfg_reg;

endpackage

>>> design/jrds_sample_if.sv
// stick sample channel
interface jrds_sample_if;
    import jrds_pkg::*;

    logic    valid;
    logic    ready;
    t_sample stick_sample;

    modport source (output valid, output stick_sample, input ready);
    modport sink (input valid, input stick_sample, output ready);
endinterface

>>> design/jrds_demand_if.sv
// platform demand channel
interface jrds_demand_if;
    import jrds_pkg::*;

    logic    valid;
    logic    ready;
    t_demand platform_demand;

    modport source (output valid, output platform_demand, input ready);
    modport sink (input valid, input platform_demand, output ready);
endinterface

>>> design/joystick_rate_demand_shaper_core.sv
// a sample passes stages s1 to s6 and then the output register before its result is offered
// throughput: one sample per cycle while the output is not held; a seven-register pipeline with one stall enable
// the two gain multipliers work in parallel in one stage, the sum and rounding follow
// a held output stalls the whole pipeline and drops ready at the input
// synchronous active-low reset empties the pipeline and loads the register defaults
module joystick_rate_demand_shaper_core #(
    parameter int DRIFT = jrds_pkg::DRIFT_DEFAULT
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [jrds_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [jrds_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    jrds_sample_if.sink                    i_sample,
    jrds_demand_if.source                  o_demand
);
    import jrds_pkg::*;

    localparam logic signed [DEMAND_W:0] DRIFT_EXT = (DEMAND_W+1)'(DRIFT);
    localparam logic [PROD_W-1:0] HALF_LSB     = PROD_W'(1) << (FRAC_SHIFT - 1);
    localparam logic [PROD_W-1:0] HALF_LSB_P1  = HALF_LSB + PROD_W'(1);
    localparam logic [MAG_W-1:0]  POS_LIMIT    = MAG_W'({1'b0, {(DEMAND_W-1){1'b1}}});
    localparam logic [MAG_W-1:0]  NEG_LIMIT    = MAG_W'({1'b1, {(DEMAND_W-1){1'b0}}});
    localparam t_demand           DEMAND_MAXV  = {1'b0, {(DEMAND_W-1){1'b1}}};
    localparam t_demand           DEMAND_MINV  = {1'b1, {(DEMAND_W-1){1'b0}}};
    localparam int                NSTAGE       = 6;

    // configuration registers
    logic signed [SAMPLE_W-1:0] r_input_offset;
    logic [DBAND_W-1:0]         r_input_deadband;
    logic [DBAND_W-1:0]         r_cutpoint;
    logic signed [GAIN_W-1:0]   r_low_gain;
    logic signed [GAIN_W-1:0]   r_high_gain;
    t_demand                    r_demand_max;
    t_demand                    r_demand_min;
    logic [ODBAND_W-1:0]        r_output_deadband;

    // pipeline
    logic                       w_adv;
    logic [NSTAGE-1:0]          r_vld;
    logic                       r_out_vld;
    t_sample                    r_s1_sample;
    logic [SAMPLE_W-1:0]        r_s2_x1;
    logic [SAMPLE_W-1:0]        r_s2_x2;
    logic                       r_s2_neg;
    logic signed [PROD_W-1:0]   r_s3_p1;
    logic signed [PROD_W-1:0]   r_s3_p2;
    logic                       r_s3_neg;
    logic signed [PROD_W-1:0]   r_s4_m;
    logic                       r_s4_neg;
    logic [MAG_W-1:0]           r_s5_mag;
    logic                       r_s5_vneg;
    t_demand                    r_s6_v;
    t_demand                    r_out_demand;

    logic signed [SAMPLE_W:0]   w_sum;
    t_sample                    w_sat;
    logic                       w_neg;
    logic [SAMPLE_W-1:0]        w_abs;
    logic [SAMPLE_W-1:0]        w_mag;
    logic                       w_inside;
    logic [SAMPLE_W-1:0]        n_x1;
    logic [SAMPLE_W-1:0]        n_x2;
    logic signed [PROD_W-1:0]   n_p1;
    logic signed [PROD_W-1:0]   n_p2;
    logic signed [PROD_W-1:0]   n_m;
    logic [PROD_W-1:0]          w_round;
    logic [MAG_W-1:0]           n_mag;
    logic                       n_vneg;
    t_demand                    w_vsat;
    t_demand                    w_vmax;
    t_demand                    n_v;
    logic [DEMAND_W-1:0]        w_vabs;
    t_demand                    w_vdz;
    logic signed [DEMAND_W:0]   w_vdrift;
    t_demand                    n_out_demand;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_input_offset    <= '0;
            r_input_deadband  <= '0;
            r_cutpoint        <= '1;
            r_low_gain        <= '0;
            r_high_gain       <= '0;
            r_demand_max      <= DEMAND_MAXV;
            r_demand_min      <= DEMAND_MINV;
            r_output_deadband <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                CFG_INPUT_OFFSET:    r_input_offset    <= i_cfg_wdata[SAMPLE_W-1:0];
                CFG_INPUT_DEADBAND:  r_input_deadband  <= i_cfg_wdata[DBAND_W-1:0];
                CFG_CUTPOINT:        r_cutpoint        <= i_cfg_wdata[DBAND_W-1:0];
                CFG_LOW_GAIN:        r_low_gain        <= i_cfg_wdata[GAIN_W-1:0];
                CFG_HIGH_GAIN:       r_high_gain       <= i_cfg_wdata[GAIN_W-1:0];
                CFG_DEMAND_MAX:      r_demand_max      <= i_cfg_wdata[DEMAND_W-1:0];
                CFG_DEMAND_MIN:      r_demand_min      <= i_cfg_wdata[DEMAND_W-1:0];
                CFG_OUTPUT_DEADBAND: r_output_deadband <= i_cfg_wdata[ODBAND_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_adv          = !r_out_vld || o_demand.ready;
    assign i_sample.ready = w_adv;

    // offset, saturate, magnitude, input deadband, slope split
    always_comb begin
        w_sum = {r_s1_sample[SAMPLE_W-1], r_s1_sample}
              + {r_input_offset[SAMPLE_W-1], r_input_offset};
        if (w_sum[SAMPLE_W] != w_sum[SAMPLE_W-1]) begin
            w_sat = w_sum[SAMPLE_W] ? {1'b1, {(SAMPLE_W-1){1'b0}}}
                                    : {1'b0, {(SAMPLE_W-1){1'b1}}};
        end else begin
            w_sat = w_sum[SAMPLE_W-1:0];
        end
        w_neg    = w_sat[SAMPLE_W-1];
        // full negative sample maps to 32768, which still fits unsigned
        w_abs    = w_neg ? (~w_sat + SAMPLE_W'(1)) : w_sat;
        w_mag    = (w_abs < {1'b0, r_input_deadband}) ? '0 : w_abs;
        w_inside = w_mag < {1'b0, r_cutpoint};
        n_x1     = w_inside ? w_mag : {1'b0, r_cutpoint};
        n_x2     = w_inside ? '0 : (w_mag - {1'b0, r_cutpoint});
    end

    assign n_p1 = r_low_gain * $signed({1'b0, r_s2_x1});
    assign n_p2 = r_high_gain * $signed({1'b0, r_s2_x2});
    assign n_m  = r_s3_p1 + r_s3_p2;

    // round to nearest, ties away from zero, on the magnitude
    always_comb begin
        w_round = r_s4_m[PROD_W-1] ? (~r_s4_m + HALF_LSB_P1) : (r_s4_m + HALF_LSB);
        n_mag   = w_round[PROD_W-1:FRAC_SHIFT];
        n_vneg  = r_s4_m[PROD_W-1] ^ r_s4_neg;
    end

    // saturate, then upper clamp, then lower clamp
    always_comb begin
        if (r_s5_vneg) begin
            w_vsat = (r_s5_mag > NEG_LIMIT) ? DEMAND_MINV
                                            : (~r_s5_mag[DEMAND_W-1:0] + DEMAND_W'(1));
        end else begin
            w_vsat = (r_s5_mag > POS_LIMIT) ? DEMAND_MAXV : r_s5_mag[DEMAND_W-1:0];
        end
        w_vmax = (w_vsat > r_demand_max) ? r_demand_max : w_vsat;
        n_v    = (w_vmax < r_demand_min) ? r_demand_min : w_vmax;
    end

    // output deadband and drift
    always_comb begin
        w_vabs   = r_s6_v[DEMAND_W-1] ? (~r_s6_v + DEMAND_W'(1)) : r_s6_v;
        w_vdz    = (w_vabs < {1'b0, r_output_deadband}) ? '0 : r_s6_v;
        w_vdrift = {w_vdz[DEMAND_W-1], w_vdz} + DRIFT_EXT;
        if (w_vdrift[DEMAND_W] != w_vdrift[DEMAND_W-1]) begin
            n_out_demand = w_vdrift[DEMAND_W] ? DEMAND_MINV : DEMAND_MAXV;
        end else begin
            n_out_demand = w_vdrift[DEMAND_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_vld     <= {r_vld[NSTAGE-2:0], i_sample.valid};
            r_out_vld <= r_vld[NSTAGE-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_sample  <= i_sample.stick_sample;
            r_s2_x1      <= n_x1;
            r_s2_x2      <= n_x2;
            r_s2_neg     <= w_neg;
            r_s3_p1      <= n_p1;
            r_s3_p2      <= n_p2;
            r_s3_neg     <= r_s2_neg;
            r_s4_m       <= n_m;
            r_s4_neg     <= r_s3_neg;
            r_s5_mag     <= n_mag;
            r_s5_vneg    <= n_vneg;
            r_s6_v       <= n_v;
            r_out_demand <= n_out_demand;
        end
    end

    assign o_demand.valid           = r_out_vld;
    assign o_demand.platform_demand = r_out_demand;

endmodule

>>> design/jrds_checker.sv
// port-level checks for the joystick rate demand shaper, bound to the top level
`include "joystick_rate_demand_shaper_core_macros.svh"

module jrds_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [jrds_pkg::DEMAND_W-1:0] i_out_demand
);
    import jrds_pkg::*;

    // reset leaves nothing to offer
    `JRDS_ASSERT_NEXT_ANY(a_reset_empties, !i_rst_n, !i_out_valid)
    // only a held output may stop the input side
    `JRDS_ASSERT_NOW(a_ready_when_free, !i_out_valid || i_out_ready, i_in_ready)
    `JRDS_ASSERT_NEXT(a_valid_holds, i_out_valid && !i_out_ready, i_out_valid)
    `JRDS_ASSERT_NEXT(a_data_holds, i_out_valid && !i_out_ready, $stable(i_out_demand))

endmodule

bind joystick_rate_demand_shaper_core jrds_checker u_jrds_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_sample.ready),
    .i_out_valid  (o_demand.valid),
    .i_out_ready  (o_demand.ready),
    .i_out_demand (o_demand.platform_demand)
);

>>> dv/joystick_rate_demand_shaper_core_test.sv
// testbench for the joystick rate demand shaper core: random traffic against a predictor
`timescale 1ns / 1ps

module joystick_rate_demand_shaper_core_test;
    import jrds_pkg::*;

    localparam int DRIFT_Q16      = DRIFT_DEFAULT;
    localparam int NUM_REGS       = 2 ** CFG_IDX_W;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 190;
    localparam int DRAIN_CYCLES   = 12;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 3000;

    class demand_scoreboard;
        longint  offset;
        longint  in_dband;
        longint  cut;
        longint  lo_gain;
        longint  hi_gain;
        longint  dmax;
        longint  dmin;
        longint  out_dband;
        t_demand expected_q[$];
        int      errors;

        function new();
            offset    = 0;
            in_dband  = 0;
            cut       = 32767;
            lo_gain   = 0;
            hi_gain   = 0;
            dmax      = 64'sd2147483647;
            dmin      = -64'sd2147483648;
            out_dband = 0;
            errors    = 0;
        endfunction

        function void write_reg(t_cfg_reg idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_INPUT_OFFSET:    offset    = $signed(data[15:0]);
                CFG_INPUT_DEADBAND:  in_dband  = longint'(data[14:0]);
                CFG_CUTPOINT:        cut       = longint'(data[14:0]);
                CFG_LOW_GAIN:        lo_gain   = $signed(data);
                CFG_HIGH_GAIN:       hi_gain   = $signed(data);
                CFG_DEMAND_MAX:      dmax      = $signed(data);
                CFG_DEMAND_MIN:      dmin      = $signed(data);
                CFG_OUTPUT_DEADBAND: out_dband = longint'(data[30:0]);
                default: ;
            endcase
        endfunction

        function longint clip(longint v, longint lo, longint hi);
            if (v > hi) return hi;
            if (v < lo) return lo;
            return v;
        endfunction

        function t_demand shape_demand(t_sample x);
            longint s;
            longint a;
            longint m;
            longint mag;
            longint v;
            bit     neg;
            s   = clip(longint'(x) + offset, -32768, 32767);
            neg = s < 0;
            a   = neg ? -s : s;
            if (a < in_dband)
                a = 0;
            if (a < cut)
                m = lo_gain * a;
            else
                m = lo_gain * cut + hi_gain * (a - cut);
            // round the q.31 product to q16.16, ties away from zero
            mag = ((m < 0 ? -m : m) + 16384) >> 15;
            v   = (m < 0) ? -mag : mag;
            if (neg)
                v = -v;
            v = clip(v, -64'sd2147483648, 64'sd2147483647);
            if (v > dmax) v = dmax;
            if (v < dmin) v = dmin;
            if ((v < 0 ? -v : v) < out_dband)
                v = 0;
            v = clip(v + DRIFT_Q16, -64'sd2147483648, 64'sd2147483647);
            return v[31:0];
        endfunction

        function void note_sample(t_sample x);
            expected_q.push_back(shape_demand(x));
        endfunction

        function void check_demand(t_demand got);
            t_demand want;
            if (expected_q.size() == 0) begin
                $error("platform_demand: expected none, actual %0d", got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got !== want) begin
                $error("platform_demand: expected %0d, actual %0d", want, got);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic [CFG_DATA_W-1:0] cfg_image [NUM_REGS];

    int tx_idle_pct   = 0;
    int rx_stall_pct  = 0;
    int hold_requests = 0;
    int holds_served  = 0;
    int idle_cycles   = 0;

    demand_scoreboard sb = new();

    jrds_sample_if sample_ch ();
    jrds_demand_if demand_ch ();

    joystick_rate_demand_shaper_core #(
        .DRIFT(DRIFT_Q16)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_wdata(cfg_wdata),
        .i_sample   (sample_ch),
        .o_demand   (demand_ch)
    );

    always #6 i_clk = ~i_clk;

    // transfers seen at the edge; the sample is noted before any result is checked
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (sample_ch.valid && sample_ch.ready)
                sb.note_sample(sample_ch.stick_sample);
            if (demand_ch.valid && demand_ch.ready)
                sb.check_demand(demand_ch.platform_demand);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (sample_ch.valid && sample_ch.ready)
                || (demand_ch.valid && demand_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    initial begin
        forever begin
            if (hold_requests != holds_served) begin
                demand_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                holds_served = hold_requests;
            end else begin
                demand_ch.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
                @(posedge i_clk);
            end
        end
    end

    task automatic send_sample(input t_sample x);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            sample_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        sample_ch.valid        <= 1'b1;
        sample_ch.stick_sample <= x;
        @(posedge i_clk);
        while (!sample_ch.ready) @(posedge i_clk);
    endtask

    task automatic wait_idle();
        sample_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_config();
        for (int i = 0; i < NUM_REGS; i++) begin
            cfg_we    <= 1'b1;
            cfg_idx   <= t_cfg_reg'(i);
            cfg_wdata <= cfg_image[i];
            @(posedge i_clk);
            sb.write_reg(t_cfg_reg'(i), cfg_image[i]);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] extreme_or_random();
        case ($urandom_range(0, 7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] small_gain();
        return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
    endfunction

    task automatic randomize_config();
        logic [31:0] lim;
        lim = $urandom_range(1, 32'h0004_0000);
        case ($urandom_range(0, 2))
            0:       cfg_image[CFG_INPUT_OFFSET] = 32'h0;
            1:       cfg_image[CFG_INPUT_OFFSET] = ($urandom & 32'hFFFF_0000)
                                                 | (($urandom_range(0, 4000) - 2000) & 32'hFFFF);
            default: cfg_image[CFG_INPUT_OFFSET] = $urandom;
        endcase
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: cfg_image[CFG_INPUT_DEADBAND] = 32'h0;
            5, 6, 7:       cfg_image[CFG_INPUT_DEADBAND] = $urandom_range(0, 2000);
            default:       cfg_image[CFG_INPUT_DEADBAND] = $urandom;
        endcase
        case ($urandom_range(0, 3))
            0:       cfg_image[CFG_CUTPOINT] = ($urandom & 32'hFFFF_8000) | 32'h7FFF;
            1:       cfg_image[CFG_CUTPOINT] = 32'h0;
            default: cfg_image[CFG_CUTPOINT] = $urandom;
        endcase
        cfg_image[CFG_LOW_GAIN]  = $urandom_range(0, 2) == 0 ? extreme_or_random() : small_gain();
        cfg_image[CFG_HIGH_GAIN] = $urandom_range(0, 2) == 0 ? extreme_or_random() : small_gain();
        case ($urandom_range(0, 3))
            0: begin
                cfg_image[CFG_DEMAND_MAX] = 32'h7FFF_FFFF;
                cfg_image[CFG_DEMAND_MIN] = 32'h8000_0000;
            end
            1: begin
                cfg_image[CFG_DEMAND_MAX] = lim;
                cfg_image[CFG_DEMAND_MIN] = -lim;
            end
            2: begin
                // crossed limits
                cfg_image[CFG_DEMAND_MAX] = -lim;
                cfg_image[CFG_DEMAND_MIN] = lim;
            end
            default: begin
                cfg_image[CFG_DEMAND_MAX] = extreme_or_random();
                cfg_image[CFG_DEMAND_MIN] = extreme_or_random();
            end
        endcase
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: cfg_image[CFG_OUTPUT_DEADBAND] = 32'h0;
            6, 7, 8:          cfg_image[CFG_OUTPUT_DEADBAND] = ($urandom & 32'h8000_0000)
                                                             | $urandom_range(0, 32'h0002_0000);
            default:          cfg_image[CFG_OUTPUT_DEADBAND] = $urandom;
        endcase
    endtask

    function automatic t_sample pick_sample();
        int ofs;
        int target;
        int s;
        ofs = $signed(cfg_image[CFG_INPUT_OFFSET][15:0]);
        case ($urandom_range(0, 5))
            0, 1: return t_sample'($urandom);
            2: begin
                case ($urandom_range(0, 4))
                    0:       return 16'sh7FFF;
                    1:       return 16'sh8000;
                    2:       return 16'sh0000;
                    3:       return 16'sh0001;
                    default: return 16'shFFFF;
                endcase
            end
            3, 4: begin
                // land next to the slope switch or the deadband edge after the offset
                if ($urandom_range(0, 1) == 0)
                    target = int'(cfg_image[CFG_CUTPOINT][14:0]);
                else
                    target = int'(cfg_image[CFG_INPUT_DEADBAND][14:0]);
                target = target + int'($urandom_range(0, 6)) - 3;
                s = ($urandom_range(0, 1) == 0 ? target : -target) - ofs;
                if (s > 32767) s = 32767;
                if (s < -32768) s = -32768;
                return t_sample'(s);
            end
            default: return t_sample'(int'($urandom_range(0, 512)) - 256);
        endcase
    endfunction

    initial begin
        i_rst_n                <= 1'b0;
        cfg_we                 <= 1'b0;
        cfg_idx                <= CFG_INPUT_OFFSET;
        cfg_wdata              <= '0;
        sample_ch.valid        <= 1'b0;
        sample_ch.stick_sample <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset values: both gains zero, so only drift comes out
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(16'sh0000);
        wait_idle();

        // linear curve, upper register bits set to junk
        cfg_image[CFG_INPUT_OFFSET]    = 32'hABCD_0000;
        cfg_image[CFG_INPUT_DEADBAND]  = 32'hFFFF_0000;
        cfg_image[CFG_CUTPOINT]        = 32'h1234_7FFF;
        cfg_image[CFG_LOW_GAIN]        = 32'h0001_0000;
        cfg_image[CFG_HIGH_GAIN]       = 32'h0001_0000;
        cfg_image[CFG_DEMAND_MAX]      = 32'h7FFF_FFFF;
        cfg_image[CFG_DEMAND_MIN]      = 32'h8000_0000;
        cfg_image[CFG_OUTPUT_DEADBAND] = 32'h8000_0000;
        load_config();
        send_sample(16'sh8000);
        send_sample(16'sh7FFF);
        send_sample(16'sh0001);
        send_sample(16'shFFFF);
        send_sample(16'sh4000);
        send_sample(-16'sd16385);
        wait_idle();

        // zero cutpoint, extreme gains, most negative offset
        cfg_image[CFG_INPUT_OFFSET]    = 32'h0000_8000;
        cfg_image[CFG_INPUT_DEADBAND]  = 32'd100;
        cfg_image[CFG_CUTPOINT]        = 32'h0;
        cfg_image[CFG_LOW_GAIN]        = 32'h7FFF_FFFF;
        cfg_image[CFG_HIGH_GAIN]       = 32'h8000_0000;
        cfg_image[CFG_OUTPUT_DEADBAND] = 32'h0;
        load_config();
        send_sample(16'sh7FFF);
        send_sample(16'sd32000);
        send_sample(16'sh8000);
        send_sample(16'sh0000);
        send_sample(16'sd100);
        wait_idle();

        // lower limit above upper limit
        cfg_image[CFG_INPUT_OFFSET]    = 32'h0000_7FFF;
        cfg_image[CFG_INPUT_DEADBAND]  = 32'h0;
        cfg_image[CFG_CUTPOINT]        = 32'd16384;
        cfg_image[CFG_LOW_GAIN]        = 32'h0001_2345;
        cfg_image[CFG_HIGH_GAIN]       = 32'hFFFE_0000;
        cfg_image[CFG_DEMAND_MAX]      = -32'sd1000;
        cfg_image[CFG_DEMAND_MIN]      = 32'sd1000;
        cfg_image[CFG_OUTPUT_DEADBAND] = 32'd500;
        load_config();
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(16'sd5);
        send_sample(-16'sd5);
        wait_idle();

        // output deadband with full range limits
        cfg_image[CFG_INPUT_OFFSET]    = 32'h0;
        cfg_image[CFG_INPUT_DEADBAND]  = 32'd10;
        cfg_image[CFG_CUTPOINT]        = 32'd20000;
        cfg_image[CFG_LOW_GAIN]        = 32'h7FFF_FFFF;
        cfg_image[CFG_HIGH_GAIN]       = 32'h8000_0000;
        cfg_image[CFG_DEMAND_MAX]      = 32'h7FFF_FFFF;
        cfg_image[CFG_DEMAND_MIN]      = 32'h8000_0000;
        cfg_image[CFG_OUTPUT_DEADBAND] = 32'h0004_0000;
        load_config();
        send_sample(16'sd1);
        send_sample(16'sd11);
        send_sample(-16'sd12);
        send_sample(16'sd20000);
        send_sample(16'sh8000);
        wait_idle();

        for (int p = 0; p < PHASES; p++) begin
            randomize_config();
            load_config();
            case (p % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 86; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 86; end
                default: begin tx_idle_pct = 24; rx_stall_pct = 24; end
            endcase
            // long output hold while samples keep coming, so the pipeline backs up
            if (p % 4 == 0)
                hold_requests = hold_requests + 1;
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_sample(pick_sample());
            wait_idle();
        end

        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
